>>> design/multichannel_window_averager_assert.svh
// Assertion macros shared by the checkers of the window averager.
`ifndef MULTICHANNEL_WINDOW_AVERAGER_ASSERT_SVH
`define MULTICHANNEL_WINDOW_AVERAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWA_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MWA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> design/mwa_pkg.sv
// Shared constants, types and helpers of the multichannel window averager.
`default_nettype none

package mwa_pkg;

  // Sizing of the block.
  localparam int MAX_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int MASK_W       = 16;
  localparam int CH_W         = 4;
  localparam int CNT_W        = 5;
  localparam int SUM_W        = 28;
  localparam int WIN_W        = 16;
  localparam int DIVR_W       = WIN_W + 1;
  localparam int STEP_W       = $clog2(SUM_W + 1);
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [SUM_W-1:0]       SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {SAMPLE_BITS{1'b1}};

  // Physical channels that exist; mask bits above them are ignored.
  localparam logic [MASK_W-1:0] CH_LIMIT_MASK = (MAX_CHANNELS >= MASK_W) ?
      {MASK_W{1'b1}} : MASK_W'((1 << MAX_CHANNELS) - 1);

  // Register indexes, decoded from address bit 2.
  localparam logic REG_IDX_MASK   = 1'b0;
  localparam logic REG_IDX_WINDOW = 1'b1;

  localparam logic [MASK_W-1:0] MASK_RESET   = 16'h0001;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd1000;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_SCAN,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;
    logic div_start_n;
    logic load_divisor;
    logic div_start_ch;
    logic ch_next;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic window_close;
    logic ch_enabled;
    logic div_done;
    logic out_free;
    logic last_slot;
  } status_t;

  // Number of set bits in a channel mask.
  function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + CNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/mwa_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mwa_divider
  import mwa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic [SUM_W-1:0]       quotient
);

  logic [DIVR_W-1:0]  rem;
  logic [DIVR_W-1:0]  dvs;
  logic [STEP_W-1:0]  steps;
  logic               busy;
  logic [DIVR_W:0]    rem_shift;
  logic [DIVR_W:0]    rem_sub;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    rem_shift = {rem, quotient[SUM_W-1]};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  // Control: busy after start until every quotient bit is shifted in, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (rem_shift >= {1'b0, dvs}) begin
        rem      <= rem_sub[DIVR_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[DIVR_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> design/mwa_datapath.sv
// Datapath: registers, channel sums, divider and output register.
`default_nettype none

module mwa_datapath
  import mwa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  // Result register.
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CH_W-1:0]             out_channel,
  output logic [SAMPLE_BITS-1:0]      out_average,
  output logic                        out_last
);

  logic [MASK_W-1:0]  channel_mask;
  logic [WIN_W-1:0]   window_samples;
  logic [CNT_W-1:0]   n_chan;
  logic [SUM_W-1:0]   channel_sums [MAX_CHANNELS];
  logic [WIN_W-1:0]   window_count;
  logic [CH_W-1:0]    scan_position;
  logic [DIVR_W-1:0]  divisor;
  logic [CH_W-1:0]    ch;
  logic [CH_W-1:0]    emit_slot;

  logic [MASK_W-1:0]  mask_eff;
  logic [DIVR_W-1:0]  win;
  logic [CH_W-1:0]    pos_eff;
  logic [CNT_W-1:0]   pos_inc;
  logic [CH_W-1:0]    pos_next;
  logic [CH_W-1:0]    rd_addr;
  logic [SUM_W-1:0]   rd_sum;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_new;
  logic [DIVR_W-1:0]  count_inc;
  logic [SUM_W-1:0]   div_dividend;
  logic [DIVR_W-1:0]  div_divisor;
  logic               div_done;
  logic [SUM_W-1:0]   div_quot;
  logic [SAMPLE_BITS-1:0] avg_sat;
  logic               cfg_wr;
  logic               clear_window;

  // Effective window, slot and saturating accumulate.
  always_comb begin
    mask_eff  = channel_mask & CH_LIMIT_MASK;
    win       = (window_samples == '0) ? {1'b1, {WIN_W{1'b0}}} : {1'b0, window_samples};
    pos_eff   = ({1'b0, scan_position} >= n_chan) ? '0 : scan_position;
    pos_inc   = {1'b0, pos_eff} + 1'b1;
    pos_next  = (pos_inc >= n_chan) ? '0 : pos_inc[CH_W-1:0];
    rd_addr   = cmd.take_sample ? pos_eff : emit_slot;
    rd_sum    = channel_sums[rd_addr];
    sum_add   = {1'b0, rd_sum} + (SUM_W + 1)'(sample);
    sum_new   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
    count_inc = {1'b0, window_count} + 1'b1;
  end

  // Divider operands: window over channel count, or a channel sum over the divisor.
  always_comb begin
    if (cmd.div_start_n) begin
      div_dividend = SUM_W'(win);
      div_divisor  = DIVR_W'(n_chan);
    end else begin
      div_dividend = rd_sum;
      div_divisor  = divisor;
    end
  end

  mwa_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start_n | cmd.div_start_ch),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Averages above the sample range saturate.
  always_comb begin
    avg_sat = (div_quot > SUM_W'(AVG_MAX)) ? AVG_MAX : div_quot[SAMPLE_BITS-1:0];
  end

  // Status toward the controller.
  always_comb begin
    status.n_zero       = (n_chan == '0);
    status.window_close = (count_inc >= win);
    status.ch_enabled   = mask_eff[ch];
    status.div_done     = div_done;
    status.out_free     = !out_valid || out_ready;
    status.last_slot    = (({1'b0, emit_slot} + 1'b1) == n_chan);
  end

  assign clear_window = cmd.emit && status.last_slot;

  // Configuration registers; the channel count follows the mask.
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask   <= MASK_RESET;
      window_samples <= WINDOW_RESET;
      n_chan         <= popcount(MASK_RESET & CH_LIMIT_MASK);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_MASK) begin
        channel_mask <= pwdata[MASK_W-1:0];
        n_chan       <= popcount(pwdata[MASK_W-1:0] & CH_LIMIT_MASK);
      end else begin
        window_samples <= pwdata[WIN_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == REG_IDX_MASK) begin
      prdata = APB_DATA_W'(channel_mask);
    end else begin
      prdata = APB_DATA_W'(window_samples);
    end
  end

  // Channel sums, cleared at reset and at the end of each window.
  always_ff @(posedge clk) begin
    if (rst || clear_window) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_sums[i] <= '0;
      end
    end else if (cmd.take_sample) begin
      channel_sums[pos_eff] <= sum_new;
    end
  end

  // Window counter and scan slot.
  always_ff @(posedge clk) begin
    if (rst || clear_window) begin
      window_count  <= '0;
      scan_position <= '0;
    end else if (cmd.take_sample) begin
      window_count  <= count_inc[WIN_W-1:0];
      scan_position <= pos_next;
    end
  end

  // Samples-per-channel divisor, loaded once per window, with a zero quotient taken as one.
  always_ff @(posedge clk) begin
    if (cmd.load_divisor) begin
      divisor <= (div_quot[DIVR_W-1:0] == '0) ? DIVR_W'(1) : div_quot[DIVR_W-1:0];
    end
  end

  // Emission counters: physical channel and scan slot.
  always_ff @(posedge clk) begin
    if (rst || clear_window) begin
      ch        <= '0;
      emit_slot <= '0;
    end else begin
      if (cmd.ch_next) begin
        ch <= ch + 1'b1;
      end
      if (cmd.emit) begin
        emit_slot <= emit_slot + 1'b1;
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel <= ch;
      out_average <= avg_sat;
      out_last    <= status.last_slot;
    end
  end

endmodule

`default_nettype wire

>>> design/mwa_controller.sv
// Controller state machine sequencing accumulation and end-of-window division.
`default_nettype none

module mwa_controller
  import mwa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.n_zero && status.window_close) begin
          state_next = ST_DIVN_START;
        end
      end
      ST_DIVN_START: begin
        state_next = ST_DIVN_WAIT;
      end
      ST_DIVN_WAIT: begin
        if (status.div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.ch_enabled) begin
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.last_slot ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.take_sample  = in_valid && !status.n_zero;
      end
      ST_DIVN_START: begin
        cmd.div_start_n = 1'b1;
      end
      ST_DIVN_WAIT: begin
        cmd.load_divisor = status.div_done;
      end
      ST_SCAN: begin
        cmd.div_start_ch = status.ch_enabled;
        cmd.ch_next      = !status.ch_enabled;
      end
      ST_DIV_WAIT: begin
        cmd = '0;
      end
      ST_EMIT: begin
        cmd.emit    = status.out_free;
        cmd.ch_next = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/multichannel_window_averager.sv
// Multichannel window averager: input samples in scan order in, channel averages out.
//
// The slave stream carries one ADC sample per transfer, interleaved over the channels
// enabled in channel_mask in ascending order. Each sample is added to the sum of its
// scan slot. When window_samples samples have been taken, the master stream gives one
// average per enabled channel in ascending channel order, with tlast on the final one.
// Each average is the channel sum divided by window_samples / channel count (at least 1).
// A sample that does not close a window leaves the block ready for the next one. A closing
// sample starts a shared one-bit-per-cycle divider: first for the divisor, then once per
// enabled channel, with each skipped mask bit stepped over in turn.
// Samples are not taken while the averages are produced.
// A result waits in the output register while the receiver stalls; the controller then
// holds the next average, and a new sample is taken as soon as the last one is registered.
// Reset clears the sums, the window count and the scan slot, and sets the mask to
// channel 0 and the window to 1000 samples. Register writes leave the sums untouched.
`default_nettype none

module multichannel_window_averager
  import mwa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Sample stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,   // [11:0] sample, [15:12] zero
  // Average stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [15:0]                m_tdata,   // [3:0] channel_number, [15:4] average
  output logic                       m_tlast,   // last_of_run
  // Register port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cmd_t                   cmd;
  status_t                status;
  logic [CH_W-1:0]        out_channel;
  logic [SAMPLE_BITS-1:0] out_average;

  mwa_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mwa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (s_tdata[SAMPLE_BITS-1:0]),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_channel (out_channel),
    .out_average (out_average),
    .out_last    (m_tlast)
  );

  // Result packing: channel in the low bits, average above it.
  assign m_tdata = {out_average, out_channel};
  assign pready  = 1'b1;

endmodule

`default_nettype wire

>>> design/mwa_checker.sv
// Port-level checker for the multichannel window averager, bound to the top level.
`default_nettype none
`include "multichannel_window_averager_assert.svh"

module mwa_checker
  import mwa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [15:0]           m_tdata,
  input wire logic                  m_tlast,
  input wire logic                  pready
);

  // A stalled result keeps its contents.
  `MWA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Once ready for a sample, the block stays ready until a transfer.
  `MWA_ASSERT_NEXT(a_in_ready_hold, clk, rst, s_tready && !s_tvalid, s_tready)

  // No result appears while the block is waiting for samples.
  `MWA_ASSERT_NEXT(a_no_result_when_idle, clk, rst, s_tready && !s_tvalid && !m_tvalid, !m_tvalid)

  // The register port never inserts wait states.
  `MWA_ASSERT_NOW(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind multichannel_window_averager mwa_checker u_mwa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

`default_nettype wire
